// ===== src/filtered_overwrite_log_ring_defines.svh =====
// Assertion macros used by the log ring RTL.
`ifndef FILTERED_OVERWRITE_LOG_RING_DEFINES_SVH
`define FILTERED_OVERWRITE_LOG_RING_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge outside reset.
`define FLR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising edge outside reset.
`define FLR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define FLR_ASSERT_IMPL(label, clk, rst, ante, cons)
`define FLR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/flr_pkg.sv =====
package flr_pkg;

   // Field widths of the request, response and configuration port.
   localparam int CMD_W       = 3;
   localparam int LEVEL_W     = 3;
   localparam int CATEGORY_W  = 16;
   localparam int MODULE_W    = 8;
   localparam int WORD_W      = 32;
   localparam int INDEX_W     = 10;
   localparam int MATCH_W     = 11;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   // Reset values.
   localparam logic [LEVEL_W-1:0]    LEVEL_FLOOR_RESET   = 3'd2;
   localparam logic [CATEGORY_W-1:0] CATEGORY_MASK_RESET = 16'hFFFF;
   localparam logic [WORD_W-1:0]     SEQ_RESET           = 32'd1;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE          = 3'd0,
      CMD_READ           = 3'd1,
      CMD_CLEAR          = 3'd2,
      CMD_COUNT_LEVEL    = 3'd3,
      CMD_COUNT_CATEGORY = 3'd4
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LEVEL_FLOOR   = 1'd0,
      CSR_CATEGORY_MASK = 1'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COUNT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [CMD_W-1:0]      cmd;
      logic [LEVEL_W-1:0]    level;
      logic [CATEGORY_W-1:0] category;
      logic [MODULE_W-1:0]   source_id;
      logic [WORD_W-1:0]     event_word;
      logic [WORD_W-1:0]     time_ms;
      logic [INDEX_W-1:0]    index;
   } req_type;

   typedef struct packed {
      logic                  ok;
      logic                  stored;
      logic [LEVEL_W-1:0]    out_level;
      logic [CATEGORY_W-1:0] out_category;
      logic [MODULE_W-1:0]   out_module;
      logic [WORD_W-1:0]     out_event;
      logic [WORD_W-1:0]     out_time;
      logic [WORD_W-1:0]     out_seq;
      logic [MATCH_W-1:0]    match_count;
      logic [WORD_W-1:0]     total_written;
      logic [WORD_W-1:0]     dropped_total;
   } rsp_type;

   // Stored entry, split over the two memories.
   typedef struct packed {
      logic [WORD_W-1:0]     seq;
      logic [MODULE_W-1:0]   source_id;
      logic [CATEGORY_W-1:0] category;
      logic [LEVEL_W-1:0]    level;
   } meta_type;

   typedef struct packed {
      logic [WORD_W-1:0] time_ms;
      logic [WORD_W-1:0] event_word;
   } data_type;

   // Finished response handed from the controller to the output stage.
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } done_type;

endpackage

// ===== src/flr_chan_if.sv =====
interface flr_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== src/filtered_overwrite_log_ring.sv =====
// Event log ring with level and category filtering.
// A request on req_ch carries a command: write, read by age from the oldest
// entry, clear, count by exact level or count by shared category bits.
// Every request gives exactly one response on rsp_ch, in request order.
// Writes, reads, clears and unknown commands go from acceptance to the finish
// state, where the response register loads once it is free, then back to idle
// for the next request. Count commands walk the stored entries through the
// metadata memory, one read per cycle, before finishing. The entry memories
// have a registered read port. The level floor and category mask are to be
// written by the user on the csr_ port only while idle; the block itself does not enforce it.
// Reset empties the ring, restarts the sequence number at 1, zeroes both
// counters and restores the register defaults; no clearing pass is needed,
// since entries beyond the fill are never read.
// When the receiver stalls, the response waits in the output register; one
// more request can be accepted and processed, then the block holds its
// finished response until the output register frees up.
`include "filtered_overwrite_log_ring_defines.svh"

module filtered_overwrite_log_ring #(
   parameter int DEPTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [flr_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [flr_pkg::CSR_DATA_W-1:0]       csr_wdata,
   flr_chan_if.sink                             req_ch,
   flr_chan_if.source                           rsp_ch
);

   import flr_pkg::*;

   logic [LEVEL_W-1:0]    level_floor_ff;
   logic [CATEGORY_W-1:0] category_mask_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;
   logic                  out_free;
   logic                  ctrl_ready;
   done_type              ctrl_done;

   flr_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_data      (req_ch.data),
      .req_ready     (ctrl_ready),
      .level_floor   (level_floor_ff),
      .category_mask (category_mask_ff),
      .out_free      (out_free),
      .done          (ctrl_done)
   );

   assign req_ch.ready = ctrl_ready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         level_floor_ff   <= LEVEL_FLOOR_RESET;
         category_mask_ff <= CATEGORY_MASK_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_LEVEL_FLOOR:   level_floor_ff   <= LEVEL_W'(csr_wdata);
            CSR_CATEGORY_MASK: category_mask_ff <= CATEGORY_W'(csr_wdata);
         endcase
      end
   end

   // Output register: loads a finished response when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= ctrl_done.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && ctrl_done.valid) begin
         rsp_data_ff <= ctrl_done.data;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   // One request at a time: after acceptance the block is busy.
   `FLR_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready)
   // A response is only handed over when the output register can take it.
   `FLR_ASSERT_IMPL(a_done_needs_room, clock, reset, ctrl_done.valid, out_free && !req_ch.ready)
   // A stored write always reports success.
   `FLR_ASSERT_IMPL(a_stored_is_ok, clock, reset, ctrl_done.valid && ctrl_done.data.stored, ctrl_done.data.ok)

endmodule

// ===== src/flr_ram.sv =====
module flr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/flr_ctrl.sv =====
module flr_ctrl #(
   parameter int DEPTH = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  flr_pkg::req_type                 req_data,
   output logic                             req_ready,
   input  logic [flr_pkg::LEVEL_W-1:0]      level_floor,
   input  logic [flr_pkg::CATEGORY_W-1:0]   category_mask,
   input  logic                             out_free,
   output flr_pkg::done_type                done
);

   import flr_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = ((PTR_W > INDEX_W) ? PTR_W : INDEX_W) + 1;
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_FILL = CNT_W'(DEPTH);
   localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);

   state_type              state_ff, state_in;
   logic [PTR_W-1:0]       write_ptr_ff, write_ptr_in;
   logic [PTR_W-1:0]       oldest_ptr_ff, oldest_ptr_in;
   logic [CNT_W-1:0]       fill_ff, fill_in;
   logic                   full_ff, full_in;
   logic [WORD_W-1:0]      seq_ff, seq_in;
   logic [WORD_W-1:0]      written_ff, written_in;
   logic [WORD_W-1:0]      overwrite_ff, overwrite_in;

   logic                   ok_ff, ok_in;
   logic                   stored_ff, stored_in;
   logic                   read_ok_ff, read_ok_in;
   logic                   counted_ff, counted_in;
   logic                   by_level_ff, by_level_in;
   logic [LEVEL_W-1:0]     level_ff, level_in;
   logic [CATEGORY_W-1:0]  category_ff, category_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       left_ff, left_in;
   logic [PTR_W-1:0]       slot_ff, slot_in;

   logic                   mem_we;
   logic                   mem_re;
   logic [PTR_W-1:0]       mem_raddr;
   meta_type               meta_wr;
   data_type               data_wr;
   meta_type               meta_rd;
   data_type               data_rd;

   logic [SUM_W-1:0]       read_sum;
   logic [PTR_W-1:0]       read_slot;
   logic                   read_hit;
   logic                   write_pass;
   logic                   match;
   logic                   done_valid;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      next_slot = (p == LAST_SLOT) ? '0 : PTR_W'(p + 1'b1);
   endfunction

   // Entry storage: metadata and payload words share one address.
   flr_ram #(
      .WIDTH ($bits(meta_type)),
      .DEPTH (DEPTH)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (write_ptr_ff),
      .wr_data (meta_wr),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (meta_rd)
   );

   flr_ram #(
      .WIDTH ($bits(data_type)),
      .DEPTH (DEPTH)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (write_ptr_ff),
      .wr_data (data_wr),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (data_rd)
   );

   // Read position from the oldest entry, folded back into the ring.
   always_comb begin
      read_sum  = SUM_W'(oldest_ptr_ff) + SUM_W'(req_data.index);
      read_slot = (read_sum >= DEPTH_SUM) ? PTR_W'(read_sum - DEPTH_SUM) : PTR_W'(read_sum);
      read_hit  = SUM_W'(req_data.index) < SUM_W'(fill_ff);
   end

   // Write filters and count match on the entry returned by the memory.
   assign write_pass = (req_data.level >= level_floor) &&
                       ((req_data.category & category_mask) != '0);
   assign match      = by_level_ff ? (meta_rd.level == level_ff)
                                   : ((meta_rd.category & category_ff) != '0);

   assign meta_wr = '{seq: seq_ff, source_id: req_data.source_id,
                      category: req_data.category, level: req_data.level};
   assign data_wr = '{time_ms: req_data.time_ms, event_word: req_data.event_word};

   assign req_ready = (state_ff == ST_IDLE);

   // Next state, ring bookkeeping and memory accesses.
   always_comb begin
      state_in      = state_ff;
      write_ptr_in  = write_ptr_ff;
      oldest_ptr_in = oldest_ptr_ff;
      fill_in       = fill_ff;
      full_in       = full_ff;
      seq_in        = seq_ff;
      written_in    = written_ff;
      overwrite_in  = overwrite_ff;
      ok_in         = ok_ff;
      stored_in     = stored_ff;
      read_ok_in    = read_ok_ff;
      counted_in    = counted_ff;
      by_level_in   = by_level_ff;
      level_in      = level_ff;
      category_in   = category_ff;
      count_in      = count_ff;
      left_in       = left_ff;
      slot_in       = slot_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_raddr     = slot_ff;
      done_valid    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in   = ST_FINISH;
               ok_in      = 1'b0;
               stored_in  = 1'b0;
               read_ok_in = 1'b0;
               counted_in = 1'b0;
               unique case (cmd_type'(req_data.cmd))
                  CMD_WRITE: begin
                     ok_in = 1'b1;
                     if (write_pass) begin
                        mem_we       = 1'b1;
                        stored_in    = 1'b1;
                        seq_in       = seq_ff + 1'b1;
                        written_in   = written_ff + 1'b1;
                        write_ptr_in = next_slot(write_ptr_ff);
                        if (full_ff) begin
                           oldest_ptr_in = next_slot(oldest_ptr_ff);
                           overwrite_in  = overwrite_ff + 1'b1;
                        end else begin
                           fill_in = CNT_W'(fill_ff + 1'b1);
                           full_in = (fill_in == FULL_FILL);
                        end
                     end
                  end
                  CMD_READ: begin
                     if (read_hit) begin
                        mem_re     = 1'b1;
                        mem_raddr  = read_slot;
                        ok_in      = 1'b1;
                        read_ok_in = 1'b1;
                     end
                  end
                  CMD_CLEAR: begin
                     ok_in         = 1'b1;
                     write_ptr_in  = '0;
                     oldest_ptr_in = '0;
                     fill_in       = '0;
                     full_in       = 1'b0;
                  end
                  CMD_COUNT_LEVEL, CMD_COUNT_CATEGORY: begin
                     ok_in       = 1'b1;
                     counted_in  = 1'b1;
                     count_in    = '0;
                     by_level_in = (cmd_type'(req_data.cmd) == CMD_COUNT_LEVEL);
                     level_in    = req_data.level;
                     category_in = req_data.category;
                     if (fill_ff != '0) begin
                        // First read goes out now, the walk continues in ST_COUNT.
                        mem_re    = 1'b1;
                        mem_raddr = oldest_ptr_ff;
                        slot_in   = next_slot(oldest_ptr_ff);
                        left_in   = CNT_W'(fill_ff - 1'b1);
                        state_in  = ST_COUNT;
                     end
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end
         ST_COUNT: begin
            // One entry evaluated per cycle while the next read, if any, is issued.
            count_in = CNT_W'(count_ff + CNT_W'(match));
            if (left_ff != '0) begin
               mem_re    = 1'b1;
               mem_raddr = slot_ff;
               slot_in   = next_slot(slot_ff);
               left_in   = CNT_W'(left_ff - 1'b1);
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               done_valid = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response fields; counters already hold their values after the request.
   always_comb begin
      done.valid              = done_valid;
      done.data.ok            = ok_ff;
      done.data.stored        = stored_ff;
      done.data.out_level     = read_ok_ff ? meta_rd.level : '0;
      done.data.out_category  = read_ok_ff ? meta_rd.category : '0;
      done.data.out_module    = read_ok_ff ? meta_rd.source_id : '0;
      done.data.out_seq       = read_ok_ff ? meta_rd.seq : '0;
      done.data.out_event     = read_ok_ff ? data_rd.event_word : '0;
      done.data.out_time      = read_ok_ff ? data_rd.time_ms : '0;
      done.data.match_count   = counted_ff ? MATCH_W'(count_ff) : MATCH_W'(fill_ff);
      done.data.total_written = written_ff;
      done.data.dropped_total = overwrite_ff;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         write_ptr_ff  <= '0;
         oldest_ptr_ff <= '0;
         fill_ff       <= '0;
         full_ff       <= 1'b0;
         seq_ff        <= SEQ_RESET;
         written_ff    <= '0;
         overwrite_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         write_ptr_ff  <= write_ptr_in;
         oldest_ptr_ff <= oldest_ptr_in;
         fill_ff       <= fill_in;
         full_ff       <= full_in;
         seq_ff        <= seq_in;
         written_ff    <= written_in;
         overwrite_ff  <= overwrite_in;
      end
   end

   // Per-request working registers.
   always_ff @(posedge clock) begin
      ok_ff       <= ok_in;
      stored_ff   <= stored_in;
      read_ok_ff  <= read_ok_in;
      counted_ff  <= counted_in;
      by_level_ff <= by_level_in;
      level_ff    <= level_in;
      category_ff <= category_in;
      count_ff    <= count_in;
      left_ff     <= left_in;
      slot_ff     <= slot_in;
   end

endmodule
